@@ hdl/inl_pkg.sv @@
// Shared types and constants for the identifier and number lexer.
package inl_pkg;

    typedef enum logic [1:0] {
        MODE_START  = 2'd0,
        MODE_IDENT  = 2'd1,
        MODE_NUMBER = 2'd2
    } scan_mode_t;

    typedef enum logic [1:0] {
        KIND_IDENT  = 2'd0,
        KIND_NUMBER = 2'd1,
        KIND_ERROR  = 2'd2,
        KIND_END    = 2'd3
    } token_kind_t;

    typedef enum logic [1:0] {
        CAUSE_NONE       = 2'd0,
        CAUSE_BAD_CHAR   = 2'd1,
        CAUSE_TABLE_FULL = 2'd2,
        CAUSE_TOO_LONG   = 2'd3
    } error_cause_t;

    typedef enum logic [1:0] {
        BACK_IDLE   = 2'd0,
        BACK_SEARCH = 2'd1,
        BACK_EMIT   = 2'd2
    } back_state_t;

    localparam logic [7:0] CHAR_UPPER_A = 8'd65;
    localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
    localparam logic [7:0] CHAR_LOWER_A = 8'd97;
    localparam logic [7:0] CHAR_LOWER_Z = 8'd122;
    localparam logic [7:0] CHAR_ZERO    = 8'd48;
    localparam logic [7:0] CHAR_NINE    = 8'd57;
    localparam logic [7:0] CHAR_SPACE   = 8'd32;
    localparam logic [7:0] CHAR_NUL     = 8'd0;

    localparam int MAX_NAME_CHARS = 8;
    localparam int NAME_BITS      = 8 * MAX_NAME_CHARS;
    localparam int LEN_BITS       = 4;

    // Token handed from the front part to the back part.
    typedef struct packed {
        logic                 lookup;
        token_kind_t          kind;
        logic [63:0]          value;
        error_cause_t         cause;
        logic [NAME_BITS-1:0] name;
        logic [LEN_BITS-1:0]  len;
    } token_req_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
               (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CHAR_ZERO && c <= CHAR_NINE;
    endfunction

endpackage

@@ hdl/identifier_number_lexer_unit.sv @@
// Top level of the identifier and number lexer with symbol table.
//  channel | dir | handshake        | payload
//  s_      | in  | s_tvalid/tready  | tdata[7:0] char_code
//  m_      | out | m_tvalid/tready  | tuser[1:0] kind; tdata[31:0] value, [33:32] cause
// A byte that does not end a token only updates the front part's scan state.
// A number, error or end of line passes through the front token register, the queue and the result register to m_.
// An identifier adds a search over the filled table entries before its result is registered.
// A two-entry request queue lets the front keep scanning during a search.
// Reset clears the table fill count; entries beyond it are never read.
module identifier_number_lexer_unit #(
    parameter int TABLE_ENTRIES = 16,
    parameter int NAME_CHARS    = 8,
    parameter int VALUE_BITS    = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] token_value, [33:32] error_cause
    output logic [1:0]  m_tuser    // [1:0] token_kind
);
    import inl_pkg::*;

    logic       f_valid, f_ready, b_valid, b_ready;
    token_req_t f_tok, b_tok;
    logic [7:0] res_small;
    logic [31:0] res_value;

    inl_front #(.NAME_CHARS(NAME_CHARS), .VALUE_BITS(VALUE_BITS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_char(s_tdata),
        .tok_valid(f_valid), .tok_ready(f_ready), .tok(f_tok)
    );

    inl_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_tok),
        .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_tok)
    );

    inl_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .req_valid(b_valid), .req_ready(b_ready), .req(b_tok),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_data(res_small), .out_value(res_value)
    );

    assign m_tdata = {6'd0, res_small[3:2], res_value};
    assign m_tuser = res_small[1:0];

endmodule

@@ hdl/inl_front.sv @@
// Front part: classifies bytes, builds names and accumulates numbers.
module inl_front #(
    parameter int NAME_CHARS = 8,
    parameter int VALUE_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_char,
    output logic                tok_valid,
    input  logic                tok_ready,
    output inl_pkg::token_req_t tok
);
    import inl_pkg::*;

    localparam logic [63:0] VALUE_MAX = {64{1'b1}} >> (64 - VALUE_BITS);
    localparam logic [63:0] ACC_LIMIT = VALUE_MAX / 64'd10;

    scan_mode_t           mode_reg, mode_next;
    logic [NAME_BITS-1:0] name_reg, name_next;
    logic [LEN_BITS-1:0]  len_reg, len_next;
    logic [63:0]          acc_reg, acc_next;
    logic                 tok_valid_reg, tok_valid_next;
    token_req_t           tok_reg, tok_next;
    logic                 take;
    logic [63:0]          digit;
    logic [63:0]          times_ten;
    logic [64:0]          sum_wide;

    assign in_ready  = !tok_valid_reg || tok_ready;
    assign take      = in_valid && in_ready;
    assign tok_valid = tok_valid_reg;
    assign tok       = tok_reg;
    assign digit     = {56'd0, in_char - CHAR_ZERO};
    assign times_ten = (acc_reg << 3) + (acc_reg << 1);
    assign sum_wide  = {1'b0, times_ten} + {1'b0, digit};

    always_comb begin
        mode_next      = mode_reg;
        name_next      = name_reg;
        len_next       = len_reg;
        acc_next       = acc_reg;
        tok_valid_next = tok_valid_reg && !tok_ready;
        tok_next       = tok_reg;
        if (take) begin
            tok_next        = '0;
            tok_next.name   = name_reg;
            tok_next.len    = len_reg;
            tok_next.kind   = KIND_ERROR;
            tok_next.cause  = CAUSE_BAD_CHAR;
            priority case (mode_reg)
                MODE_IDENT: begin
                    if (is_letter(in_char) || is_digit(in_char)) begin
                        if (len_reg >= LEN_BITS'(NAME_CHARS)) begin
                            tok_next.cause = CAUSE_TOO_LONG;
                            tok_valid_next = 1'b1;
                            mode_next      = MODE_START;
                        end else begin
                            name_next[len_reg[2:0]*8 +: 8] = in_char;
                            len_next = len_reg + 1'b1;
                        end
                    end else begin
                        if (in_char == CHAR_SPACE) begin
                            tok_next.lookup = 1'b1;
                            tok_next.kind   = KIND_IDENT;
                            tok_next.cause  = CAUSE_NONE;
                        end
                        tok_valid_next = 1'b1;
                        mode_next      = MODE_START;
                    end
                end
                MODE_NUMBER: begin
                    if (is_digit(in_char)) begin
                        if (acc_reg > ACC_LIMIT ||
                            sum_wide > {1'b0, VALUE_MAX}) begin
                            acc_next = VALUE_MAX;
                        end else begin
                            acc_next = sum_wide[63:0];
                        end
                    end else begin
                        if (in_char == CHAR_SPACE) begin
                            tok_next.kind  = KIND_NUMBER;
                            tok_next.cause = CAUSE_NONE;
                            tok_next.value = acc_reg;
                        end
                        tok_valid_next = 1'b1;
                        mode_next      = MODE_START;
                    end
                end
                default: begin
                    if (is_letter(in_char)) begin
                        mode_next = MODE_IDENT;
                        name_next = '0;
                        name_next[7:0] = in_char;
                        len_next  = LEN_BITS'(1);
                    end else if (is_digit(in_char)) begin
                        mode_next = MODE_NUMBER;
                        acc_next  = digit;
                    end else begin
                        if (in_char == CHAR_NUL) begin
                            tok_next.kind  = KIND_END;
                            tok_next.cause = CAUSE_NONE;
                        end
                        tok_valid_next = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_START;
            tok_valid_reg <= 1'b0;
            len_reg       <= '0;
        end else begin
            mode_reg      <= mode_next;
            tok_valid_reg <= tok_valid_next;
            len_reg       <= len_next;
        end
        name_reg <= name_next;
        acc_reg  <= acc_next;
        tok_reg  <= tok_next;
    end

endmodule

@@ hdl/inl_queue.sv @@
// Two-entry queue of token requests between the front and back parts.
module inl_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_valid,
    output logic                wr_ready,
    input  inl_pkg::token_req_t wr_data,
    output logic                rd_valid,
    input  logic                rd_ready,
    output inl_pkg::token_req_t rd_data
);
    import inl_pkg::*;

    token_req_t  slot_reg [2];
    logic        wptr_reg, wptr_next;
    logic        rptr_reg, rptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push, pop;

    assign wr_ready = count_reg != 2'd2;
    assign rd_valid = count_reg != 2'd0;
    assign rd_data  = slot_reg[rptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wptr_next  = wptr_reg ^ push;
        rptr_next  = rptr_reg ^ pop;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
        if (push) begin
            slot_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

@@ hdl/inl_back.sv @@
// Back part: symbol table search and append, result register.
module inl_back #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                req_valid,
    output logic                req_ready,
    input  inl_pkg::token_req_t req,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_data
    , output logic [31:0]       out_value
);
    import inl_pkg::*;

    localparam int IDX_BITS = $clog2(TABLE_ENTRIES);
    localparam int CNT_BITS = $clog2(TABLE_ENTRIES + 1);

    back_state_t          state_reg, state_next;
    logic [NAME_BITS-1:0] tab_name [TABLE_ENTRIES];
    logic [LEN_BITS-1:0]  tab_len  [TABLE_ENTRIES];
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic [CNT_BITS-1:0]  idx_reg, idx_next;
    token_req_t           cur_reg;
    logic                 load;
    logic                 hit;
    logic                 append;
    logic [NAME_BITS-1:0] mask;
    logic                 out_valid_reg;
    token_kind_t          kind_reg, kind_next;
    error_cause_t         cause_reg, cause_next;
    logic [31:0]          value_reg, value_next;
    logic                 emit;

    always_comb begin
        mask = '0;
        for (int k = 0; k < MAX_NAME_CHARS; k++) begin
            if (LEN_BITS'(k) < cur_reg.len) begin
                mask[k*8 +: 8] = 8'hFF;
            end
        end
    end

    assign hit = (idx_reg < count_reg) &&
                 (tab_len[idx_reg[IDX_BITS-1:0]] == cur_reg.len) &&
                 (((tab_name[idx_reg[IDX_BITS-1:0]] ^ cur_reg.name) & mask) == '0);

    assign req_ready = (state_reg == BACK_IDLE) && (!out_valid_reg || out_ready);
    assign load      = req_valid && req_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = {4'd0, cause_reg, kind_reg};
    assign out_value = value_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BACK_IDLE: begin
                if (load && req.lookup) begin
                    state_next = BACK_SEARCH;
                end
            end
            BACK_SEARCH: begin
                if (hit || idx_reg >= count_reg) begin
                    state_next = BACK_EMIT;
                end
            end
            BACK_EMIT: begin
                if (!out_valid_reg || out_ready) begin
                    state_next = BACK_IDLE;
                end
            end
            default: state_next = BACK_IDLE;
        endcase
    end

    always_comb begin
        idx_next   = idx_reg;
        count_next = count_reg;
        kind_next  = kind_reg;
        cause_next = cause_reg;
        value_next = value_reg;
        emit       = 1'b0;
        append     = 1'b0;
        unique case (state_reg)
            BACK_IDLE: begin
                idx_next = '0;
                if (load && !req.lookup) begin
                    emit       = 1'b1;
                    kind_next  = req.kind;
                    cause_next = req.cause;
                    value_next = req.value[31:0];
                end
            end
            BACK_SEARCH: begin
                if (hit) begin
                    kind_next  = KIND_IDENT;
                    cause_next = CAUSE_NONE;
                    value_next = 32'(idx_reg);
                end else if (idx_reg >= count_reg) begin
                    if (count_reg >= CNT_BITS'(TABLE_ENTRIES)) begin
                        kind_next  = KIND_ERROR;
                        cause_next = CAUSE_TABLE_FULL;
                        value_next = '0;
                    end else begin
                        append     = 1'b1;
                        kind_next  = KIND_IDENT;
                        cause_next = CAUSE_NONE;
                        value_next = 32'(count_reg);
                        count_next = count_reg + 1'b1;
                    end
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            BACK_EMIT: begin
                emit = !out_valid_reg || out_ready;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BACK_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
        idx_reg <= idx_next;
        if (state_reg == BACK_SEARCH || emit) begin
            kind_reg  <= kind_next;
            cause_reg <= cause_next;
            value_reg <= value_next;
        end
        if (load) begin
            cur_reg <= req;
        end
        if (append) begin
            tab_name[count_reg[IDX_BITS-1:0]] <= cur_reg.name & mask;
            tab_len[count_reg[IDX_BITS-1:0]]  <= cur_reg.len;
        end
    end

endmodule

@@ hdl/inl_checker.sv @@
// Port-level checks for the lexer, bound to the top level.
module inl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import inl_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_ERROR |-> m_tdata[33:32] == CAUSE_NONE)
        else $error("cause set on non-error");
    a_errval: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_ERROR || m_tuser == KIND_END)
        |-> m_tdata[31:0] == 32'd0)
        else $error("value set on error or end");
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[39:34] == 6'd0)
        else $error("padding not zero");
endmodule

bind identifier_number_lexer_unit inl_checker u_inl_checker (.*);

@@ tb/identifier_number_lexer_unit_test.sv @@
// Testbench for the identifier and number lexer: directed table plus random lines, self-checked.
`timescale 1ns / 100ps

module identifier_number_lexer_unit_test;
    import inl_pkg::*;

    typedef struct packed {
        token_kind_t  kind;
        logic [31:0]  value;
        error_cause_t cause;
    } token_t;

    typedef struct {
        logic [7:0] ch;
        logic       typed;
        token_t     tok;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    token_t      token_queue[$];
    logic [7:0]  char_queue[$];
    stim_row_t   directed_rows[$];
    int          fail_count = 0;
    bit          stim_done = 1'b0;

    scan_mode_t  lex_mode;
    logic [7:0]  lex_name[8];
    int          lex_len;
    logic [31:0] lex_acc;
    logic [7:0]  sym_names[16][8];
    int          sym_lens[16];
    int          sym_count;

    identifier_number_lexer_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic bit letter_char(logic [7:0] c);
        return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
    endfunction

    function automatic bit digit_char(logic [7:0] c);
        return c >= 8'd48 && c <= 8'd57;
    endfunction

    function automatic token_t make_token(token_kind_t k, logic [31:0] v, error_cause_t e);
        token_t t;
        t.kind = k;
        t.value = v;
        t.cause = e;
        return t;
    endfunction

    // Advance the lexer prediction by one byte; returns 1 when a token comes out.
    function automatic bit lex_byte(logic [7:0] c, output token_t tok);
        bit hit;
        int idx;
        logic [3:0] d;
        tok = make_token(KIND_ERROR, 32'd0, CAUSE_BAD_CHAR);
        if (lex_mode == MODE_IDENT) begin
            if (letter_char(c) || digit_char(c)) begin
                if (lex_len >= 8) begin
                    tok = make_token(KIND_ERROR, 32'd0, CAUSE_TOO_LONG);
                end else begin
                    lex_name[lex_len] = c;
                    lex_len++;
                    return 1'b0;
                end
            end else if (c == CHAR_SPACE) begin
                idx = -1;
                for (int i = 0; i < sym_count; i++) begin
                    hit = (sym_lens[i] == lex_len);
                    for (int j = 0; j < lex_len; j++)
                        if (sym_names[i][j] != lex_name[j]) hit = 1'b0;
                    if (hit && idx < 0) idx = i;
                end
                if (idx >= 0) begin
                    tok = make_token(KIND_IDENT, idx, CAUSE_NONE);
                end else if (sym_count >= 16) begin
                    tok = make_token(KIND_ERROR, 32'd0, CAUSE_TABLE_FULL);
                end else begin
                    for (int j = 0; j < 8; j++) sym_names[sym_count][j] = lex_name[j];
                    sym_lens[sym_count] = lex_len;
                    tok = make_token(KIND_IDENT, sym_count, CAUSE_NONE);
                    sym_count++;
                end
            end
        end else if (lex_mode == MODE_NUMBER) begin
            if (digit_char(c)) begin
                d = 4'(c - CHAR_ZERO);
                if ({32'd0, lex_acc} * 10 + d > 64'hFFFF_FFFF) lex_acc = 32'hFFFF_FFFF;
                else lex_acc = lex_acc * 10 + d;
                return 1'b0;
            end else if (c == CHAR_SPACE) begin
                tok = make_token(KIND_NUMBER, lex_acc, CAUSE_NONE);
            end
        end else begin
            if (letter_char(c)) begin
                lex_mode = MODE_IDENT;
                lex_name[0] = c;
                lex_len = 1;
                return 1'b0;
            end
            if (digit_char(c)) begin
                lex_mode = MODE_NUMBER;
                lex_acc = 32'(c - CHAR_ZERO);
                return 1'b0;
            end
            if (c == CHAR_NUL) tok = make_token(KIND_END, 32'd0, CAUSE_NONE);
        end
        lex_mode = MODE_START;
        lex_len = 0;
        lex_acc = 32'd0;
        return 1'b1;
    endfunction

    function automatic logic [7:0] rand_letter();
        return 8'(($urandom_range(0, 1) ? 8'd65 : 8'd97) + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_alnum();
        return $urandom_range(0, 2) ? rand_letter() : 8'(CHAR_ZERO + $urandom_range(0, 9));
    endfunction

    task automatic push_chars(string s);
        for (int i = 0; i < s.len(); i++) char_queue.push_back(s[i]);
    endtask

    task automatic add_row(logic [7:0] c, bit typed, token_t t);
        stim_row_t r;
        r.ch = c;
        r.typed = typed;
        r.tok = t;
        directed_rows.push_back(r);
    endtask

    task automatic send_byte(logic [7:0] c);
        token_t t;
        s_tvalid <= 1'b1;
        s_tdata <= c;
        do @(posedge aclk); while (!s_tready);
        if (lex_byte(c, t)) token_queue.push_back(t);
    endtask

    task automatic send_pause();
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge aclk);
    endtask

    // Random line material: mostly well-formed tokens, some noise.
    task automatic build_random_line();
        int n;
        int sel;
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++) begin
            sel = $urandom_range(0, 19);
            if (sel < 8) begin
                // reuse a small name pool so lookups hit
                char_queue.push_back(8'(8'd97 + $urandom_range(0, 2)));
                repeat ($urandom_range(0, 2))
                    char_queue.push_back(8'(CHAR_ZERO + $urandom_range(0, 1)));
            end else if (sel < 11) begin
                char_queue.push_back(rand_letter());
                repeat ($urandom_range(0, 8)) char_queue.push_back(rand_alnum());
            end else if (sel < 16) begin
                char_queue.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
                repeat ($urandom_range(0, $urandom_range(0, 1) ? 3 : 12))
                    char_queue.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
            end else begin
                char_queue.push_back(8'($urandom_range(0, 255)));
            end
            char_queue.push_back($urandom_range(0, 9) ? CHAR_SPACE : 8'($urandom_range(0, 255)));
        end
        char_queue.push_back(CHAR_NUL);
    endtask

    initial begin
        token_t none;
        int sent;
        int burst;
        lex_mode = MODE_START;
        lex_len = 0;
        lex_acc = 32'd0;
        sym_count = 0;
        none = make_token(KIND_END, 32'd0, CAUSE_NONE);
        add_row(8'd0, 1, make_token(KIND_END, 32'd0, CAUSE_NONE));
        add_row(8'd32, 1, make_token(KIND_ERROR, 32'd0, CAUSE_BAD_CHAR));
        add_row(8'd255, 1, make_token(KIND_ERROR, 32'd0, CAUSE_BAD_CHAR));
        add_row("Z", 0, none);
        add_row(8'd32, 1, make_token(KIND_IDENT, 32'd0, CAUSE_NONE));
        add_row("z", 0, none);
        add_row("9", 0, none);
        add_row(8'd32, 1, make_token(KIND_IDENT, 32'd1, CAUSE_NONE));
        add_row("Z", 0, none);
        add_row(8'd32, 1, make_token(KIND_IDENT, 32'd0, CAUSE_NONE));
        add_row("0", 0, none);
        add_row(8'd32, 1, make_token(KIND_NUMBER, 32'd0, CAUSE_NONE));
        add_row("7", 0, none);
        add_row(8'd0, 1, make_token(KIND_ERROR, 32'd0, CAUSE_BAD_CHAR));
        add_row("A", 0, none);
        add_row(8'd10, 1, make_token(KIND_ERROR, 32'd0, CAUSE_BAD_CHAR));
        add_row("q", 0, none);
        add_row("-", 1, make_token(KIND_ERROR, 32'd0, CAUSE_BAD_CHAR));
        add_row("5", 0, none);
        add_row("a", 1, make_token(KIND_ERROR, 32'd0, CAUSE_BAD_CHAR));

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            send_byte(directed_rows[i].ch);
            if (directed_rows[i].typed && token_queue.size() > 0)
                token_queue[$] = directed_rows[i].tok;
            if ($urandom_range(0, 3) == 0) send_pause();
        end

        // long name, saturation, and a typo sharing a prefix with a stored name
        push_chars("abcdefgh abcdefghi 4294967295 4294967296 99999999999 abcdefg ");
        push_chars("Zz 00012 ");
        char_queue.push_back(CHAR_NUL);
        sent = 0;
        while (sent < 450) begin
            if (char_queue.size() == 0) begin
                if (sent > 200 && sent < 260 && sym_count < 16) begin
                    // fill the table to force table-full errors
                    for (int k = 0; k < 18; k++) begin
                        char_queue.push_back("x");
                        char_queue.push_back(8'(65 + k));
                        char_queue.push_back("Q");
                        char_queue.push_back(CHAR_SPACE);
                    end
                end else begin
                    build_random_line();
                end
            end
            burst = $urandom_range(1, 12);
            while (burst > 0 && char_queue.size() > 0) begin
                send_byte(char_queue.pop_front());
                sent++;
                burst--;
            end
            if (sent > 100 && sent < 115) begin
                s_tvalid <= 1'b0;
                wait (token_queue.size() == 0);
                @(posedge aclk);
            end
            if ($urandom_range(0, 2) != 0) send_pause();
        end
        s_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        m_tready <= 1'b0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            case ($urandom_range(0, 7))
                0, 1: m_tready <= 1'b0;
                default: m_tready <= 1'b1;
            endcase
        end
    end

    always @(posedge aclk) begin
        token_t want;
        token_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser, m_tdata[31:0], m_tdata[33:32]};
            if (token_queue.size() == 0) begin
                $display("%0t unexpected token: got kind %0d value %0d cause %0d",
                         $time, got.kind, got.value, got.cause);
                fail_count++;
            end else begin
                want = token_queue.pop_front();
                if (got !== want || m_tdata[39:34] !== 6'd0) begin
                    $display("%0t token: expected %0d/%0d/%0d got %0d/%0d/%0d",
                             $time, want.kind, want.value, want.cause,
                             got.kind, got.value, got.cause);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        wait (stim_done && token_queue.size() == 0);
        repeat (40) @(posedge aclk);
        if (fail_count == 0)
            $display("identifier_number_lexer_unit: match");
        else
            $display("identifier_number_lexer_unit: mismatch");
        $finish;
    end

    initial begin
        #2000000;
        $display("identifier_number_lexer_unit: mismatch");
        $finish;
    end

endmodule
